>>> hdl/sgmva_pkg.sv
// Shared constants, types and codes for the spike-gated matvec accumulator.
`timescale 1ns / 1ps
package sgmva_pkg;

    // Array dimensions
    localparam int PRE_MAX  = 64;
    localparam int POST_MAX = 32;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int POST_IDX_W = 5;
    localparam int PRE_IDX_W  = 6;
    localparam int WEIGHT_W   = 16;
    localparam int ACC_W      = 48;
    localparam int X_W        = 16;
    localparam int PRE_CNT_W  = 7;
    localparam int POST_CNT_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Derived sizes
    localparam int WS_DEPTH = PRE_MAX * POST_MAX;
    localparam int WS_ADDR_W = $clog2(WS_DEPTH);
    localparam int NPRE_W   = $clog2(PRE_MAX + 1);
    localparam int NPOST_W  = $clog2(POST_MAX + 1);
    localparam int CYC_W    = $clog2(POST_MAX + 2);
    localparam int TERM_W   = WEIGHT_W + X_W;
    localparam int SPIKE_SHIFT = 12;

    // Input tdata packing, lowest bit first
    localparam int IN_POST_LSB   = 0;
    localparam int IN_PRE_LSB    = IN_POST_LSB + POST_IDX_W;
    localparam int IN_WEIGHT_LSB = IN_PRE_LSB + PRE_IDX_W;
    localparam int IN_PRESET_LSB = IN_WEIGHT_LSB + WEIGHT_W;
    localparam int IN_X_LSB      = IN_PRESET_LSB + ACC_W;
    localparam int IN_BITS       = IN_X_LSB + X_W;
    localparam int S_TDATA_W     = ((IN_BITS + 7) / 8) * 8;

    // Output tdata packing, lowest bit first
    localparam int OUT_IDX_LSB = 0;
    localparam int OUT_SUM_LSB = OUT_IDX_LSB + POST_IDX_W;
    localparam int OUT_OVF_BIT = OUT_SUM_LSB + ACC_W;
    localparam int OUT_BITS    = OUT_OVF_BIT + 1;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WR_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INPUT     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_MODE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_RPT
    } t_state;

    // Contents of one ring cell
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic                    ovf;
    } t_cell_data;

    // Control from the sequencer to the MAC unit
    typedef struct packed {
        logic add_en;
        logic spike_mode;
    } t_mac_ctrl;

endpackage

>>> hdl/spike_gated_matvec_accumulate.sv
// Top level: spiking fully connected layer, weight RAM plus a ring of accumulator cells.
// Weight write, preset and ignored commands finish on acceptance, with tready still high.
// Input element in range: an accumulate pass, set by the one shared MAC that the
// accumulator ring rotates past, one row a cycle, behind the RAM read and product register.
// vector_end adds a report pass over the POST_MAX rows at full output rate, longer under stall.
// Reset (i_rst_n, synchronous, low): accumulators and overflow marks cleared, config to defaults.
`timescale 1ns / 1ps
module spike_gated_matvec_accumulate (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // post_index, pre_index, weight_value, preset_value, input_value, zero fill
    input  logic [sgmva_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // cmd
    input  logic [sgmva_pkg::CMD_W-1:0]           s_axis_tuser,
    // vector_end
    input  logic                                  s_axis_tlast,
    // master stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // neuron_index, neuron_sum, overflowed, zero fill
    output logic [sgmva_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // final_res
    output logic                                  m_axis_tlast,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sgmva_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sgmva_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sgmva_pkg::*;

    localparam int CYC_ACC_LAST = POST_MAX + 1;
    localparam int CYC_RPT_LAST = POST_MAX - 1;
    localparam int PIPE_DEPTH   = 2;

    // ---------------------------------------------------------------- config
    logic [PRE_CNT_W-1:0]  r_pre_count;
    logic [POST_CNT_W-1:0] r_post_count;
    logic                  r_spike_mode;
    logic [NPRE_W-1:0]     w_npre;
    logic [NPOST_W-1:0]    w_npost;
    logic [POST_IDX_W-1:0] w_last_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_count  <= PRE_CNT_W'(PRE_MAX);
            r_post_count <= POST_CNT_W'(POST_MAX);
            r_spike_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRE_COUNT:  r_pre_count  <= i_cfg_data[PRE_CNT_W-1:0];
                CFG_POST_COUNT: r_post_count <= i_cfg_data[POST_CNT_W-1:0];
                CFG_SPIKE_MODE: r_spike_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // counts in use, clamped to 1..max
    always_comb begin
        if (r_pre_count == '0) begin
            w_npre = NPRE_W'(1);
        end else if (int'(r_pre_count) > PRE_MAX) begin
            w_npre = NPRE_W'(PRE_MAX);
        end else begin
            w_npre = NPRE_W'(r_pre_count);
        end
        if (r_post_count == '0) begin
            w_npost = NPOST_W'(1);
        end else if (int'(r_post_count) > POST_MAX) begin
            w_npost = NPOST_W'(POST_MAX);
        end else begin
            w_npost = NPOST_W'(r_post_count);
        end
    end

    assign w_last_idx = POST_IDX_W'(int'(w_npost) - 1);

    // ---------------------------------------------------------- input fields
    logic                         w_s_acc;
    logic [CMD_W-1:0]             w_cmd;
    logic [POST_IDX_W-1:0]        w_in_post;
    logic [PRE_IDX_W-1:0]         w_in_pre;
    logic signed [WEIGHT_W-1:0]   w_in_weight;
    logic signed [ACC_W-1:0]      w_in_preset;
    logic signed [X_W-1:0]        w_in_x;
    logic                         w_row_ok;
    logic                         w_col_ok;
    logic                         w_col_used;

    assign w_cmd       = s_axis_tuser;
    assign w_in_post   = s_axis_tdata[IN_POST_LSB +: POST_IDX_W];
    assign w_in_pre    = s_axis_tdata[IN_PRE_LSB +: PRE_IDX_W];
    assign w_in_weight = s_axis_tdata[IN_WEIGHT_LSB +: WEIGHT_W];
    assign w_in_preset = s_axis_tdata[IN_PRESET_LSB +: ACC_W];
    assign w_in_x      = s_axis_tdata[IN_X_LSB +: X_W];

    assign w_s_acc    = s_axis_tvalid && s_axis_tready;
    assign w_row_ok   = int'(w_in_post) < POST_MAX;
    assign w_col_ok   = int'(w_in_pre) < PRE_MAX;
    assign w_col_used = int'(w_in_pre) < int'(w_npre);

    // --------------------------------------------------------- sequencer
    t_state                r_state;
    t_state                n_state;
    logic [CYC_W-1:0]      r_cyc;
    logic [CYC_W-1:0]      n_cyc;
    logic [PRE_IDX_W-1:0]  r_col;
    logic signed [X_W-1:0] r_x;
    logic                  r_vend;

    logic                  w_we;
    logic                  w_preset;
    logic                  w_shift;
    logic                  w_load_out;
    logic                  w_out_free;
    logic                  w_rpt_in_use;
    t_mac_ctrl             w_mac_ctrl;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_we          = w_s_acc && (w_cmd == CMD_WR_WEIGHT) && w_row_ok && w_col_ok;
    assign w_preset      = w_s_acc && (w_cmd == CMD_PRESET) && w_row_ok;
    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    assign w_rpt_in_use  = int'(r_cyc) < int'(w_npost);

    always_comb begin
        n_state           = r_state;
        n_cyc             = r_cyc;
        w_shift           = 1'b0;
        w_load_out        = 1'b0;
        w_mac_ctrl.add_en = 1'b0;
        w_mac_ctrl.spike_mode = r_spike_mode;
        case (r_state)
            ST_IDLE: begin
                n_cyc = '0;
                if (w_s_acc && (w_cmd == CMD_INPUT)) begin
                    if (w_col_used) begin
                        n_state = ST_ACC;
                    end else if (s_axis_tlast) begin
                        n_state = ST_RPT;
                    end
                end
            end
            ST_ACC: begin
                // rotation starts once the first product is registered
                if (int'(r_cyc) >= PIPE_DEPTH) begin
                    w_shift           = 1'b1;
                    w_mac_ctrl.add_en = (int'(r_cyc) - PIPE_DEPTH) < int'(w_npost);
                end
                if (int'(r_cyc) == CYC_ACC_LAST) begin
                    n_cyc   = '0;
                    n_state = r_vend ? ST_RPT : ST_IDLE;
                end else begin
                    n_cyc = r_cyc + CYC_W'(1);
                end
            end
            ST_RPT: begin
                // rows past post_count rotate through without a transaction
                w_shift    = !w_rpt_in_use || w_out_free;
                w_load_out = w_rpt_in_use && w_out_free;
                if (w_shift) begin
                    if (int'(r_cyc) == CYC_RPT_LAST) begin
                        n_cyc   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cyc = r_cyc + CYC_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cyc   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cyc   <= '0;
        end else begin
            r_state <= n_state;
            r_cyc   <= n_cyc;
        end
    end

    // element held for the whole pass
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_col  <= w_in_pre;
            r_x    <= w_in_x;
            r_vend <= s_axis_tlast;
        end
    end

    // ---------------------------------------------------------- weight RAM
    logic [WS_ADDR_W-1:0]       w_waddr;
    logic [WS_ADDR_W-1:0]       w_raddr;
    logic [WEIGHT_W-1:0]        w_rdata;

    assign w_waddr = WS_ADDR_W'(int'(w_in_post) * PRE_MAX + int'(w_in_pre));
    // row r_cyc passes the RAM read and product registers before it meets the head cell
    assign w_raddr = WS_ADDR_W'(int'(r_cyc) * PRE_MAX + int'(r_col));

    sgmva_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (WS_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_in_weight),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------- accumulator ring
    // Cell 0 is the head; every shift moves each cell one place toward it
    // and the MAC result enters at the tail. POST_MAX shifts bring every
    // row back to its home cell.
    t_cell_data w_cell [POST_MAX];
    t_cell_data w_tail;

    sgmva_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (w_mac_ctrl),
        .i_weight (w_rdata),
        .i_x      (r_x),
        .i_head   (w_cell[0]),
        .o_tail   (w_tail)
    );

    for (genvar k = 0; k < POST_MAX; k++) begin : g_cell
        t_cell_data w_prev;
        if (k == POST_MAX - 1) begin : g_tail
            assign w_prev = w_tail;
        end else begin : g_link
            assign w_prev = w_cell[k+1];
        end
        sgmva_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_shift),
            .i_load     (w_preset && (int'(w_in_post) == k)),
            .i_load_acc (w_in_preset),
            .i_prev     (w_prev),
            .o_data     (w_cell[k])
        );
    end

    // ------------------------------------------------- output register
    logic                    r_m_valid;
    logic [POST_IDX_W-1:0]   r_m_idx;
    logic signed [ACC_W-1:0] r_m_sum;
    logic                    r_m_ovf;
    logic                    r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_idx  <= r_cyc[POST_IDX_W-1:0];
            r_m_sum  <= w_cell[0].acc;
            r_m_ovf  <= w_cell[0].ovf;
            r_m_last <= r_cyc[POST_IDX_W-1:0] == w_last_idx;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_BITS){1'b0}}, r_m_ovf, r_m_sum, r_m_idx};

`ifndef SYNTHESIS
    // accumulate pass always ends with the ring back at home
    a_acc_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC && n_state != ST_ACC) |-> int'(r_cyc) == CYC_ACC_LAST)
        else $error("accumulate pass left ring misaligned");

    // the closing result of a run belongs to the last row in use
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> r_m_idx == w_last_idx)
        else $error("final result on wrong row");

    // results are produced only by the report pass
    a_out_from_rpt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_RPT)
        else $error("result produced outside report pass");

    // no preset or weight write while the ring is turning
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_preset || w_we) |-> !w_shift)
        else $error("store written during a pass");
`endif

endmodule

>>> hdl/sgmva_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sgmva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sgmva_cell.sv
// One ring cell: holds one accumulator and its overflow mark.
`timescale 1ns / 1ps
module sgmva_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  logic                            i_load,
    input  logic signed [sgmva_pkg::ACC_W-1:0] i_load_acc,
    input  sgmva_pkg::t_cell_data           i_prev,
    output sgmva_pkg::t_cell_data           o_data
);
    import sgmva_pkg::*;

    t_cell_data r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_load) begin
            r_data.acc <= i_load_acc;
            r_data.ovf <= 1'b0;
        end else if (i_shift) begin
            r_data <= i_prev;
        end
    end

    assign o_data = r_data;

endmodule

>>> hdl/sgmva_mac.sv
// Shared MAC: registered weight term, then saturating add onto the head cell.
`timescale 1ns / 1ps
module sgmva_mac (
    input  logic                                  i_clk,
    input  sgmva_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [sgmva_pkg::WEIGHT_W-1:0] i_weight,
    input  logic signed [sgmva_pkg::X_W-1:0]      i_x,
    input  sgmva_pkg::t_cell_data                 i_head,
    output sgmva_pkg::t_cell_data                 o_tail
);
    import sgmva_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_POS = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_NEG = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [TERM_W-1:0] n_term;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W:0]    w_sum;
    logic                     w_sat;

    // spike mode: weight widened to Q20.12 when input is positive, else zero
    always_comb begin
        if (i_ctrl.spike_mode) begin
            if (i_x > 0) begin
                n_term = TERM_W'(i_weight) <<< SPIKE_SHIFT;
            end else begin
                n_term = '0;
            end
        end else begin
            n_term = TERM_W'(i_weight) * TERM_W'(i_x);
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

    assign w_sum = (ACC_W+1)'(i_head.acc) + (ACC_W+1)'(r_term);
    assign w_sat = w_sum[ACC_W] != w_sum[ACC_W-1];

    always_comb begin
        o_tail = i_head;
        if (i_ctrl.add_en) begin
            if (w_sat) begin
                o_tail.acc = w_sum[ACC_W] ? ACC_NEG : ACC_POS;
                o_tail.ovf = 1'b1;
            end else begin
                o_tail.acc = w_sum[ACC_W-1:0];
            end
        end
    end

endmodule
